### sv/multi_input_change_debouncer_macros.svh
// Assertion macros for the multi-input change debouncer.
`ifndef MULTI_INPUT_CHANGE_DEBOUNCER_MACROS_SVH
`define MULTI_INPUT_CHANGE_DEBOUNCER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MICD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debouncer check failed");
`define MICD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debouncer check failed");
`else
`define MICD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MICD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/micd_pkg.sv
// Shared constants and types for the multi-input change debouncer.
`timescale 1ns / 1ps
`default_nettype none

package micd_pkg;

  localparam int MAX_CHIPS     = 4;
  localparam int BITS_PER_CHIP = 8;
  localparam int SCAN_W        = 32;
  localparam int SLOTS         = SCAN_W / BITS_PER_CHIP;
  localparam int IDX_W         = $clog2(SCAN_W);
  localparam int CFG_W         = 3;
  localparam int CODE_W        = 7;
  localparam int CNT_W         = 2;

  localparam logic [CFG_W-1:0] CHIPS_RESET   = CFG_W'(4);
  localparam logic [CNT_W-1:0] COUNT_MAX     = CNT_W'(3);
  localparam logic [CNT_W-1:0] CONFIRM_LIMIT = CNT_W'(2);

  typedef struct packed {
    logic             found;
    logic             rise;
    logic [IDX_W-1:0] idx;
  } change_t;

endpackage

`default_nettype wire

### sv/multi_input_change_debouncer.sv
// Multi-input change debouncer: top level with handshake and debounce state.
//
// Usage:
//   Input channel (in_valid/in_ready, scan_bits): one request per scan of all
//   32 inputs. Output channel (out_valid/out_ready, event_code): exactly one
//   request per scan, +(n+1) for a confirmed rise of input n, -(n+1) for a
//   confirmed fall, 0 otherwise. Config channel (cfg_valid/cfg_ready, chips_in_use):
//   always ready; write only while the block is idle.
//   A scan accepted is registered in the input stage; its result is registered
//   in the output register. Throughput: one scan per cycle while the output is
//   not stalled; the change detect, priority encode and counter update are
//   combinational between the input stage and the output register.
//   Reset: chips_in_use = 4, accepted levels, pending code and count cleared,
//   both stages empty.
//   Stall: while the output register holds an untaken result, one more scan
//   is held in the input stage; after that in_ready drops until out_ready.
`timescale 1ns / 1ps
`default_nettype none

module multi_input_change_debouncer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [micd_pkg::SCAN_W-1:0]   scan_bits,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic signed [micd_pkg::CODE_W-1:0] event_code,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [micd_pkg::CFG_W-1:0]    chips_in_use
);
  import micd_pkg::*;

  `include "multi_input_change_debouncer_macros.svh"

  logic                     stage_full;
  logic [SCAN_W-1:0]        stage_scan;
  logic [CFG_W-1:0]         chip_count;
  logic [SCAN_W-1:0]        accepted_levels;
  logic [SCAN_W-1:0]        accepted_levels_next;
  logic signed [CODE_W-1:0] pending_code;
  logic signed [CODE_W-1:0] pending_code_next;
  logic [CNT_W-1:0]         repeat_count;
  logic [CNT_W-1:0]         repeat_count_next;
  logic signed [CODE_W-1:0] emit_code;
  logic signed [CODE_W-1:0] code;
  logic [CODE_W-1:0]        code_mag;
  logic                     advance;
  change_t                  change;

  micd_detect u_detect (
    .scan            (stage_scan),
    .accepted_levels (accepted_levels),
    .chip_count      (chip_count),
    .change          (change)
  );

  assign advance   = stage_full && (!out_valid || out_ready);
  assign in_ready  = !stage_full || advance;
  assign cfg_ready = 1'b1;

  assign code_mag = CODE_W'(change.idx) + CODE_W'(1);
  assign code     = !change.found ? '0 :
                    (change.rise ? $signed(code_mag) : -$signed(code_mag));

  always_comb begin
    accepted_levels_next = accepted_levels;
    pending_code_next    = pending_code;
    repeat_count_next    = repeat_count;
    emit_code            = '0;
    if (change.found) begin
      if (code != pending_code) begin
        pending_code_next = code;
        repeat_count_next = '0;
      end else begin
        repeat_count_next = (repeat_count == COUNT_MAX) ? COUNT_MAX :
                            repeat_count + CNT_W'(1);
        if (repeat_count_next > CONFIRM_LIMIT) begin
          emit_code = code;
          accepted_levels_next[change.idx] = change.rise;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_full      <= 1'b0;
      out_valid       <= 1'b0;
      chip_count      <= CHIPS_RESET;
      accepted_levels <= '0;
      pending_code    <= '0;
      repeat_count    <= '0;
    end else begin
      if (cfg_valid) begin
        chip_count <= chips_in_use;
      end
      if (in_ready) begin
        stage_full <= in_valid;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        accepted_levels <= accepted_levels_next;
        pending_code    <= pending_code_next;
        repeat_count    <= repeat_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_scan <= scan_bits;
    end
    if (advance) begin
      event_code <= emit_code;
    end
  end

  // a shown nonzero event is the confirmed pending code
  `MICD_ASSERT_IMPLIES(a_event_matches_state, clk, rst,
    out_valid && (event_code != '0),
    (repeat_count == COUNT_MAX) && (pending_code == event_code))

  // accepted levels move only together with a nonzero event
  `MICD_ASSERT_IMPLIES(a_levels_move_on_event, clk, rst,
    !$past(rst) && !$stable(accepted_levels),
    out_valid && (event_code != '0))

  // both stages full and stalled: no new scan taken, output held
  `MICD_ASSERT_NEXT(a_stall_holds, clk, rst,
    stage_full && out_valid && !out_ready,
    out_valid && stage_full && $stable(event_code))

endmodule

`default_nettype wire

### sv/micd_detect.sv
// Masked change detect and highest-input priority encode.
`timescale 1ns / 1ps
`default_nettype none

module micd_detect (
  input  wire logic [micd_pkg::SCAN_W-1:0] scan,
  input  wire logic [micd_pkg::SCAN_W-1:0] accepted_levels,
  input  wire logic [micd_pkg::CFG_W-1:0]  chip_count,
  output micd_pkg::change_t                change
);
  import micd_pkg::*;

  logic [CFG_W:0]    eff_chips;
  logic [SCAN_W-1:0] mask;
  logic [SCAN_W-1:0] diff;

  // chip counts above the supported maximum act as the maximum
  assign eff_chips = ({1'b0, chip_count} > (CFG_W+1)'(MAX_CHIPS)) ?
                     (CFG_W+1)'(MAX_CHIPS) : {1'b0, chip_count};

  always_comb begin
    mask = '0;
    for (int c = 0; c < SLOTS; c++) begin
      mask[c*BITS_PER_CHIP +: BITS_PER_CHIP] =
        {BITS_PER_CHIP{((CFG_W+1)'(c) < eff_chips)}};
    end
  end

  assign diff = (scan ^ accepted_levels) & mask;

  // last hit wins: highest-numbered changed input
  always_comb begin
    change = '0;
    for (int k = 0; k < SCAN_W; k++) begin
      if (diff[k]) begin
        change.found = 1'b1;
        change.idx   = IDX_W'(k);
        change.rise  = scan[k];
      end
    end
  end

endmodule

`default_nettype wire

### verif/tb_multi_input_change_debouncer.sv
// Self-checking testbench for the multi-input change debouncer.
`timescale 1ns / 1ps

module tb_multi_input_change_debouncer;
  import micd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 68;

  // Tracks accepted levels, pending code and repeat count; queues expected codes.
  class debounce_scoreboard;
    logic [SCAN_W-1:0]        accepted;
    logic signed [CODE_W-1:0] pending;
    logic [CNT_W-1:0]         repeats;
    logic [CFG_W-1:0]         chips;
    logic signed [CODE_W-1:0] expected_codes[$];
    int                       errors;

    function new();
      accepted = '0;
      pending  = '0;
      repeats  = '0;
      chips    = CHIPS_RESET;
      errors   = 0;
    endfunction

    function void set_chips(logic [CFG_W-1:0] value);
      chips = value;
    endfunction

    function int outstanding();
      return expected_codes.size();
    endfunction

    function void note_scan(logic [SCAN_W-1:0] scan);
      int                       eff;
      int                       nbits;
      int                       mag;
      logic [SCAN_W-1:0]        mask;
      logic [SCAN_W-1:0]        diff;
      logic signed [CODE_W-1:0] code;
      logic signed [CODE_W-1:0] emitted;
      eff   = (chips > MAX_CHIPS) ? MAX_CHIPS : int'(chips);
      nbits = eff * BITS_PER_CHIP;
      mask  = (nbits >= SCAN_W) ? '1 : ((SCAN_W'(1) << nbits) - SCAN_W'(1));
      diff  = (scan ^ accepted) & mask;
      code  = '0;
      // ascending scan, so the highest differing input wins
      for (int k = 0; k < SCAN_W; k++) begin
        if (diff[k]) begin
          code = scan[k] ? CODE_W'(k + 1) : -CODE_W'(k + 1);
        end
      end
      emitted = '0;
      if (code != 0) begin
        if (code != pending) begin
          pending = code;
          repeats = '0;
        end else begin
          if (repeats < COUNT_MAX) repeats++;
          if (repeats > CONFIRM_LIMIT) begin
            mag = (code > 0) ? int'(code) : -int'(code);
            emitted = code;
            accepted[mag - 1] = (code > 0);
          end
        end
      end
      expected_codes.push_back(emitted);
    endfunction

    function void check_code(logic signed [CODE_W-1:0] got);
      logic signed [CODE_W-1:0] want;
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected event_code %0d, no scan outstanding", $time, got);
        errors++;
        return;
      end
      want = expected_codes.pop_front();
      if (got !== want) begin
        $display("%0t: event_code mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  wire logic                in_ready;
  logic [SCAN_W-1:0]        scan_bits;
  wire logic                out_valid;
  logic                     out_ready;
  wire logic signed [CODE_W-1:0] event_code;
  logic                     cfg_valid;
  wire logic                cfg_ready;
  logic [CFG_W-1:0]         chips_in_use;

  debounce_scoreboard sb;
  int                 idle_pct;
  int                 stall_pct;
  int                 cycles;
  logic [SCAN_W-1:0]  cur_target;

  logic [SCAN_W-1:0] directed_scans[$] = '{
    32'h0000_0000, 32'h0000_0000,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
    // a no-change scan in the middle must not disturb the pending count
    32'h0000_0003, 32'h0000_0001, 32'h0000_0003, 32'h0000_0003, 32'h0000_0003,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  logic [CFG_W-1:0] chips_plan[8] = '{3'd7, 3'd1, 3'd0, 3'd4, 3'd2, 3'd5, 3'd3, 3'd4};

  multi_input_change_debouncer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .scan_bits   (scan_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_code  (event_code),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .chips_in_use(chips_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // request monitor: config first, then results, then new scans
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_chips(chips_in_use);
      if (out_valid && out_ready) sb.check_code(event_code);
      if (in_valid && in_ready) sb.note_scan(scan_bits);
    end
  end

  task automatic send_scan(input logic [SCAN_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    scan_bits <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  task automatic write_chips(input logic [CFG_W-1:0] value);
    drain();
    repeat (3) @(posedge clk);
    cfg_valid    <= 1'b1;
    chips_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int sent;
    int reps;
    int roll;
    int w;
    int b;
    sent = 0;
    w = ((sb.chips > MAX_CHIPS) ? MAX_CHIPS : int'(sb.chips)) * BITS_PER_CHIP;
    if (w == 0) w = SCAN_W;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        // well-formed: nudge a few bits and hold long enough to confirm
        repeat ($urandom_range(1, 3)) begin
          b = ($urandom_range(99) < 85) ? $urandom_range(w - 1) : $urandom_range(SCAN_W - 1);
          cur_target[b] = ~cur_target[b];
        end
        reps = $urandom_range(4, 12);
        while (reps > 0 && sent < n) begin
          send_scan(cur_target);
          sent++;
          reps--;
        end
      end else if (roll < 92) begin
        b = $urandom_range(w - 1);
        send_scan(cur_target ^ (SCAN_W'(1) << b));
        sent++;
      end else begin
        send_scan($urandom());
        sent++;
      end
    end
  endtask

  initial begin
    sb           = new();
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    cur_target   = '0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    scan_bits    <= '0;
    cfg_valid    <= 1'b0;
    chips_in_use <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_scans[i]) send_scan(directed_scans[i]);

    for (int p = 0; p < 8; p++) begin
      write_chips(chips_plan[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      random_phase(PHASE_ITEMS / 2);
      if (p == 3) drain();
      random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.outstanding() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
